### hw/rtl/ldc_pkg.sv
// Shared types and constants for the load disconnect controller.
package ldc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned AcTimerWidth  = 13;

  localparam logic [CfgIndexWidth-1:0] RegDisconnectMode    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegDisconnectVoltage = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegRecoverVoltage    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegAcLossDelay       = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegUndervoltReload   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegRecoverReload     = 3'd5;

  localparam logic [1:0] ModeNone    = 2'd0;
  localparam logic [1:0] ModeVoltage = 2'd1;
  localparam logic [1:0] ModeAcLoss  = 2'd2;
  localparam logic [1:0] ModeForced  = 2'd3;

  localparam logic [1:0] AlarmNone    = 2'd0;
  localparam logic [1:0] AlarmRaised  = 2'd1;
  localparam logic [1:0] AlarmCleared = 2'd2;

  localparam logic [1:0] CauseVolt = 2'b01;
  localparam logic [1:0] CauseAc   = 2'b10;

  localparam logic [15:0] DisconnectVoltageReset = 16'd4500;
  localparam logic [15:0] RecoverVoltageReset    = 16'd5300;
  localparam logic [7:0]  UndervoltReloadReset   = 8'd20;
  localparam logic [7:0]  RecoverReloadReset     = 8'd30;
  localparam logic [AcTimerWidth-1:0] AcTimerReset = 13'd5;
  localparam logic [AcTimerWidth-1:0] AcTimerStep  = 13'd1;

  typedef struct packed {
    logic [15:0] bus_voltage;
    logic [15:0] battery_voltage;
    logic        battery_discharging;
    logic        ac_present;
    logic        timing_enabled;
    logic        second_tick;
  } item_t;

  typedef struct packed {
    logic       relay_open;
    logic       relay_changed;
    logic [1:0] alarm_event;
    logic       disconnect_latched;
    logic       undervolt_cause;
    logic       ac_timeout_cause;
    logic       supply_stopped;
  } result_t;

  typedef struct packed {
    logic [1:0]  disconnect_mode;
    logic [15:0] disconnect_voltage;
    logic [15:0] recover_voltage;
    logic [9:0]  ac_loss_delay;
    logic [7:0]  undervolt_reload;
    logic [7:0]  recover_reload;
  } cfg_t;

  typedef struct packed {
    logic                    ac_flag;
    logic [AcTimerWidth-1:0] ac_loss_timer;
    logic [7:0]              undervolt_timer;
    logic [7:0]              recover_timer;
    logic [1:0]              cause_bits;
    logic                    latched;
    logic                    relay_state;
  } state_t;

endpackage

### hw/rtl/load_disconnect_controller.sv
// Top level of one load disconnect controller channel.
//
// Items enter on item/item_valid/item_stall and are accepted when item_valid
// is high and item_stall is low. Each accepted item produces exactly one
// result on result/result_valid/result_stall, taken when result_valid is high
// and result_stall is low. Settings are written on the cfg port, which is
// always ready, and should change only while no item is in flight.
// An accepted item is held in an input register; when the result register
// can take it, the item's update runs through one short combinational step
// against the channel state and lands in the result register. Throughput
// is one item per cycle unless the receiver stalls, set by that update.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item before item_stall rises.
// Reset is synchronous: it empties both registers, loads the default
// settings and returns the state to AC present with the relay closed.
module load_disconnect_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  ldc_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output ldc_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ldc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [ldc_pkg::CfgDataWidth-1:0]   cfg_data
);

  ldc_pkg::cfg_t    cfg;
  ldc_pkg::state_t  state;
  ldc_pkg::state_t  state_next;
  ldc_pkg::item_t   held;
  ldc_pkg::result_t result_next;
  logic             held_valid;
  logic             advance;

  ldc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ldc_update u_update (
    .cfg        (cfg),
    .state      (state),
    .item       (held),
    .state_next (state_next),
    .result     (result_next)
  );

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.ac_flag         <= 1'b1;
      state.ac_loss_timer   <= ldc_pkg::AcTimerReset;
      state.undervolt_timer <= ldc_pkg::UndervoltReloadReset;
      state.recover_timer   <= ldc_pkg::RecoverReloadReset;
      state.cause_bits      <= 2'b00;
      state.latched         <= 1'b0;
      state.relay_state     <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/ldc_cfg.sv
// Configuration register file of the load disconnect controller.
module ldc_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ldc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [ldc_pkg::CfgDataWidth-1:0]    cfg_data,
  output ldc_pkg::cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disconnect_mode    <= ldc_pkg::ModeNone;
      cfg.disconnect_voltage <= ldc_pkg::DisconnectVoltageReset;
      cfg.recover_voltage    <= ldc_pkg::RecoverVoltageReset;
      cfg.ac_loss_delay      <= '0;
      cfg.undervolt_reload   <= ldc_pkg::UndervoltReloadReset;
      cfg.recover_reload     <= ldc_pkg::RecoverReloadReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        ldc_pkg::RegDisconnectMode:    cfg.disconnect_mode    <= cfg_data[1:0];
        ldc_pkg::RegDisconnectVoltage: cfg.disconnect_voltage <= cfg_data;
        ldc_pkg::RegRecoverVoltage:    cfg.recover_voltage    <= cfg_data;
        ldc_pkg::RegAcLossDelay:       cfg.ac_loss_delay      <= cfg_data[9:0];
        ldc_pkg::RegUndervoltReload:   cfg.undervolt_reload   <= cfg_data[7:0];
        ldc_pkg::RegRecoverReload:     cfg.recover_reload     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/ldc_update.sv
// Next-state and result logic for one item of the load disconnect controller.
module ldc_update (
  input  ldc_pkg::cfg_t    cfg,
  input  ldc_pkg::state_t  state,
  input  ldc_pkg::item_t   item,
  output ldc_pkg::state_t  state_next,
  output ldc_pkg::result_t result
);

  logic                                 bus_low;
  logic                                 bat_low;
  logic                                 bus_high;
  logic                                 bat_high;
  logic                                 bat_above_dis;
  logic [ldc_pkg::AcTimerWidth-1:0]     ac_load;
  logic                                 changed;
  logic [1:0]                           alarm;

  assign bus_low       = item.bus_voltage < cfg.disconnect_voltage;
  assign bat_low       = item.battery_voltage < cfg.disconnect_voltage;
  assign bus_high      = item.bus_voltage > cfg.recover_voltage;
  assign bat_high      = item.battery_voltage > cfg.recover_voltage;
  assign bat_above_dis = item.battery_voltage > cfg.disconnect_voltage;
  assign ac_load = {1'b0, cfg.ac_loss_delay, 2'b00} + {2'b00, cfg.ac_loss_delay, 1'b0};

  always_comb begin
    state_next = state;
    changed    = 1'b0;
    alarm      = ldc_pkg::AlarmNone;

    if (!item.ac_present) begin
      if (state.ac_flag) begin
        state_next.ac_loss_timer = ac_load;
        state_next.ac_flag       = 1'b0;
      end
    end else begin
      state_next.ac_flag = 1'b1;
    end

    if (item.timing_enabled) begin
      if (item.second_tick) begin
        if (!state_next.ac_flag && state_next.cause_bits == 2'b00 &&
            state_next.ac_loss_timer != '0) begin
          state_next.ac_loss_timer = state_next.ac_loss_timer - ldc_pkg::AcTimerStep;
        end
        if (bus_low || bat_low) begin
          if (state_next.undervolt_timer != 8'd0) begin
            state_next.undervolt_timer = state_next.undervolt_timer - 8'd1;
          end
        end else begin
          state_next.undervolt_timer = cfg.undervolt_reload;
        end
        if (bus_high && bat_high) begin
          if (state_next.recover_timer != 8'd0) begin
            state_next.recover_timer = state_next.recover_timer - 8'd1;
          end
        end else begin
          state_next.recover_timer = cfg.recover_reload;
        end
      end

      case (cfg.disconnect_mode)
        ldc_pkg::ModeNone: begin
          if (state_next.latched) begin
            state_next.latched = 1'b0;
            alarm = ldc_pkg::AlarmCleared;
          end
          if (state_next.relay_state) begin
            state_next.relay_state = 1'b0;
            changed = 1'b1;
          end
        end
        ldc_pkg::ModeForced: begin
          if (!state_next.latched) begin
            state_next.latched = 1'b1;
            alarm = ldc_pkg::AlarmRaised;
          end
          if (!state_next.relay_state) begin
            state_next.relay_state = 1'b1;
            changed = 1'b1;
          end
        end
        default: begin
          if (!state_next.ac_flag && state_next.ac_loss_timer == '0 &&
              cfg.disconnect_mode == ldc_pkg::ModeAcLoss) begin
            if (!state_next.latched) begin
              state_next.latched = 1'b1;
              alarm = ldc_pkg::AlarmRaised;
            end
            state_next.cause_bits = state_next.cause_bits | ldc_pkg::CauseAc;
          end
          if ((bus_low || (bat_low && item.battery_discharging)) &&
              state_next.undervolt_timer == 8'd0) begin
            if (!state_next.latched) begin
              state_next.latched = 1'b1;
              alarm = ldc_pkg::AlarmRaised;
            end
            state_next.cause_bits = state_next.cause_bits | ldc_pkg::CauseVolt;
          end
          if (bus_high && bat_above_dis && state_next.recover_timer == 8'd0) begin
            state_next.cause_bits = state_next.cause_bits & ~ldc_pkg::CauseVolt;
            if (state_next.ac_flag) begin
              state_next.cause_bits = state_next.cause_bits & ~ldc_pkg::CauseAc;
            end
          end
          if (state_next.cause_bits != 2'b00) begin
            if (!state_next.relay_state) begin
              state_next.relay_state = 1'b1;
              changed = 1'b1;
            end
          end else begin
            if (state_next.relay_state) begin
              state_next.relay_state = 1'b0;
              changed = 1'b1;
            end
            if (state_next.latched) begin
              state_next.latched = 1'b0;
              alarm = ldc_pkg::AlarmCleared;
            end
          end
        end
      endcase
    end

    result.relay_open         = state_next.relay_state;
    result.relay_changed      = changed;
    result.alarm_event        = alarm;
    result.disconnect_latched = state_next.latched;
    result.undervolt_cause    = state_next.cause_bits[0];
    result.ac_timeout_cause   = state_next.cause_bits[1];
    result.supply_stopped     = ~state_next.ac_flag;
  end

endmodule

### dv/load_disconnect_controller_tb.sv
// Self-checking testbench for one load disconnect controller channel.
`timescale 1ns / 100ps

module load_disconnect_controller_tb;

  localparam int unsigned AcDelayScale  = 6;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned PrintLimit    = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  ldc_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ldc_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ldc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [ldc_pkg::CfgDataWidth-1:0] cfg_data = '0;

  ldc_pkg::cfg_t settings;
  ldc_pkg::state_t plant;
  ldc_pkg::result_t pending_outcomes[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit no_gap_stretch = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  load_disconnect_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Advances the channel state by one item and returns the result it causes.
  function automatic ldc_pkg::result_t predict_outcome(input ldc_pkg::item_t it);
    ldc_pkg::result_t r;
    logic changed;
    logic [1:0] alarm;
    logic [31:0] ac_load;
    changed = 1'b0;
    alarm = ldc_pkg::AlarmNone;
    if (!it.ac_present) begin
      if (plant.ac_flag) begin
        ac_load = 32'(settings.ac_loss_delay) * AcDelayScale;
        plant.ac_loss_timer = ac_load[ldc_pkg::AcTimerWidth-1:0];
        plant.ac_flag = 1'b0;
      end
    end else begin
      plant.ac_flag = 1'b1;
    end
    if (it.timing_enabled) begin
      if (it.second_tick) begin
        if (!plant.ac_flag && plant.cause_bits == 2'b00 && plant.ac_loss_timer != '0) begin
          plant.ac_loss_timer = plant.ac_loss_timer - ldc_pkg::AcTimerStep;
        end
        if (it.bus_voltage < settings.disconnect_voltage ||
            it.battery_voltage < settings.disconnect_voltage) begin
          if (plant.undervolt_timer != '0) plant.undervolt_timer = plant.undervolt_timer - 8'd1;
        end else begin
          plant.undervolt_timer = settings.undervolt_reload;
        end
        if (it.bus_voltage > settings.recover_voltage &&
            it.battery_voltage > settings.recover_voltage) begin
          if (plant.recover_timer != '0) plant.recover_timer = plant.recover_timer - 8'd1;
        end else begin
          plant.recover_timer = settings.recover_reload;
        end
      end
      case (settings.disconnect_mode)
        ldc_pkg::ModeNone: begin
          if (plant.latched) begin
            plant.latched = 1'b0;
            alarm = ldc_pkg::AlarmCleared;
          end
          if (plant.relay_state) begin
            plant.relay_state = 1'b0;
            changed = 1'b1;
          end
        end
        ldc_pkg::ModeForced: begin
          if (!plant.latched) begin
            plant.latched = 1'b1;
            alarm = ldc_pkg::AlarmRaised;
          end
          if (!plant.relay_state) begin
            plant.relay_state = 1'b1;
            changed = 1'b1;
          end
        end
        default: begin
          if (!plant.ac_flag && plant.ac_loss_timer == '0 &&
              settings.disconnect_mode == ldc_pkg::ModeAcLoss) begin
            if (!plant.latched) begin
              plant.latched = 1'b1;
              alarm = ldc_pkg::AlarmRaised;
            end
            plant.cause_bits = plant.cause_bits | ldc_pkg::CauseAc;
          end
          if ((it.bus_voltage < settings.disconnect_voltage ||
               (it.battery_voltage < settings.disconnect_voltage && it.battery_discharging)) &&
              plant.undervolt_timer == '0) begin
            if (!plant.latched) begin
              plant.latched = 1'b1;
              alarm = ldc_pkg::AlarmRaised;
            end
            plant.cause_bits = plant.cause_bits | ldc_pkg::CauseVolt;
          end
          if (it.bus_voltage > settings.recover_voltage &&
              it.battery_voltage > settings.disconnect_voltage && plant.recover_timer == '0) begin
            plant.cause_bits = plant.cause_bits & ~ldc_pkg::CauseVolt;
            if (plant.ac_flag) plant.cause_bits = plant.cause_bits & ~ldc_pkg::CauseAc;
          end
          if (plant.cause_bits != 2'b00) begin
            if (!plant.relay_state) begin
              plant.relay_state = 1'b1;
              changed = 1'b1;
            end
          end else begin
            if (plant.relay_state) begin
              plant.relay_state = 1'b0;
              changed = 1'b1;
            end
            if (plant.latched) begin
              plant.latched = 1'b0;
              alarm = ldc_pkg::AlarmCleared;
            end
          end
        end
      endcase
    end
    r.relay_open = plant.relay_state;
    r.relay_changed = changed;
    r.alarm_event = alarm;
    r.disconnect_latched = plant.latched;
    r.undervolt_cause = plant.cause_bits[0];
    r.ac_timeout_cause = plant.cause_bits[1];
    r.supply_stopped = ~plant.ac_flag;
    return r;
  endfunction

  function automatic ldc_pkg::item_t make_item(input logic [15:0] bus, input logic [15:0] bat,
                                               input logic dis, input logic acp,
                                               input logic ten, input logic tick);
    ldc_pkg::item_t it;
    it.bus_voltage = bus;
    it.battery_voltage = bat;
    it.battery_discharging = dis;
    it.ac_present = acp;
    it.timing_enabled = ten;
    it.second_tick = tick;
    return it;
  endfunction

  // Voltages cluster around the thresholds so that the timers really run.
  function automatic logic [15:0] pick_level();
    int v;
    case ($urandom_range(0, 7))
      0: v = int'($urandom_range(0, 65535));
      1: v = $urandom_range(0, 1) ? 65535 : 0;
      2, 3: v = int'(settings.disconnect_voltage) + int'($urandom_range(0, 600)) - 300;
      4, 5: v = int'(settings.recover_voltage) + int'($urandom_range(0, 600)) - 300;
      6: v = int'(settings.disconnect_voltage) + int'($urandom_range(0, 2)) - 1;
      default: v = int'(settings.recover_voltage) + int'($urandom_range(0, 2)) - 1;
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic send_item(input ldc_pkg::item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gap_stretch ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(it));
  endtask

  // Stops the sender and waits until every result has been taken.
  task automatic settle_block(input int unsigned pad);
    item_valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic apply_settings(input ldc_pkg::cfg_t s);
    logic [ldc_pkg::CfgIndexWidth-1:0] idx;
    logic [ldc_pkg::CfgDataWidth-1:0] val;
    for (int i = ldc_pkg::RegDisconnectMode; i <= ldc_pkg::RegRecoverReload; i++) begin
      idx = i[ldc_pkg::CfgIndexWidth-1:0];
      case (idx)
        ldc_pkg::RegDisconnectMode:    val = 16'(s.disconnect_mode);
        ldc_pkg::RegDisconnectVoltage: val = s.disconnect_voltage;
        ldc_pkg::RegRecoverVoltage:    val = s.recover_voltage;
        ldc_pkg::RegAcLossDelay:       val = 16'(s.ac_loss_delay);
        ldc_pkg::RegUndervoltReload:   val = 16'(s.undervolt_reload);
        default:                       val = 16'(s.recover_reload);
      endcase
      cfg_index <= idx;
      cfg_data <= val;
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    settings = s;
  endtask

  task automatic test_power_on_defaults();
    send_item(make_item(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1));
    send_item(make_item(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1));
    send_item(make_item(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_corner_cases();
    ldc_pkg::cfg_t s;
    s = settings;
    settle_block(3);
    s.disconnect_mode = ldc_pkg::ModeForced;
    apply_settings(s);
    send_item(make_item(16'd4000, 16'd4000, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b0));

    // Releasing in mode none keeps the cause bits.
    settle_block(3);
    s.disconnect_mode = ldc_pkg::ModeNone;
    apply_settings(s);
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b1));

    settle_block(3);
    s.disconnect_mode = ldc_pkg::ModeVoltage;
    s.disconnect_voltage = 16'd5000;
    s.recover_voltage = 16'd1000;
    s.undervolt_reload = 8'd0;
    s.recover_reload = 8'd0;
    apply_settings(s);
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd500, 16'd500, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b1));
    // Bus between the two thresholds raises and clears the alarm in one item.
    send_item(make_item(16'd3000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd3000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd3000, 1'b1, 1'b1, 1'b1, 1'b1));
    // The battery has to clear the disconnect threshold before recovery.
    send_item(make_item(16'd6000, 16'd4000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b0));

    settle_block(3);
    s.disconnect_mode = ldc_pkg::ModeAcLoss;
    s.ac_loss_delay = 10'd1;
    apply_settings(s);
    repeat (6) send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(16'd6000, 16'd6000, 1'b0, 1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_random_operation();
    ldc_pkg::cfg_t s;
    ldc_pkg::item_t it;
    logic [35:0] raw;
    logic [15:0] bus_level;
    logic [15:0] bat_level;
    logic ac_level;
    ac_level = 1'b1;
    for (int p = 0; p < 12; p++) begin
      if (p < 4) s.disconnect_mode = p[1:0];
      else if ($urandom_range(0, 3) == 0) s.disconnect_mode = 2'($urandom_range(0, 3));
      else s.disconnect_mode = $urandom_range(0, 1) ? ldc_pkg::ModeVoltage : ldc_pkg::ModeAcLoss;
      if (p == 1) s.disconnect_voltage = 16'h0000;
      else if (p == 2) s.disconnect_voltage = 16'hFFFF;
      else s.disconnect_voltage = 16'($urandom_range(3000, 6000));
      if (p == 3) s.recover_voltage = 16'h0000;
      else if (p == 5) s.recover_voltage = 16'hFFFF;
      else s.recover_voltage = 16'(s.disconnect_voltage + $urandom_range(0, 1500));
      if (p == 6) s.ac_loss_delay = 10'd999;
      else if (p == 9) s.ac_loss_delay = 10'd0;
      else s.ac_loss_delay = 10'($urandom_range(0, 3));
      if (p == 4) s.undervolt_reload = 8'd0;
      else if (p == 7) s.undervolt_reload = 8'd255;
      else s.undervolt_reload = 8'($urandom_range(0, 6));
      if (p == 4) s.recover_reload = 8'd0;
      else if (p == 8) s.recover_reload = 8'd255;
      else s.recover_reload = 8'($urandom_range(0, 6));
      settle_block(3);
      apply_settings(s);
      no_gap_stretch = ($urandom_range(0, 2) == 0);
      bus_level = pick_level();
      bat_level = pick_level();
      for (int n = 0; n < 92; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          raw = 36'({$urandom, $urandom});
          it = raw;
        end else begin
          if ($urandom_range(0, 7) == 0) bus_level = pick_level();
          if ($urandom_range(0, 7) == 0) bat_level = pick_level();
          if ($urandom_range(0, 15) == 0) ac_level = ~ac_level;
          it = make_item(bus_level, bat_level, 1'($urandom_range(0, 1)), ac_level,
                         $urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
        end
        send_item(it);
      end
    end
  endtask

  // Result side: checks each taken result and stalls on its own pattern.
  always @(posedge clk) begin
    ldc_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("relay_open", 2'(result.relay_open), 2'(want.relay_open));
          compare_field("relay_changed", 2'(result.relay_changed), 2'(want.relay_changed));
          compare_field("alarm_event", result.alarm_event, want.alarm_event);
          compare_field("disconnect_latched", 2'(result.disconnect_latched),
                        2'(want.disconnect_latched));
          compare_field("undervolt_cause", 2'(result.undervolt_cause),
                        2'(want.undervolt_cause));
          compare_field("ac_timeout_cause", 2'(result.ac_timeout_cause),
                        2'(want.ac_timeout_cause));
          compare_field("supply_stopped", 2'(result.supply_stopped), 2'(want.supply_stopped));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 2) == 0);
        2: result_stall <= ~result_stall;
        default: result_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    settings.disconnect_mode = ldc_pkg::ModeNone;
    settings.disconnect_voltage = ldc_pkg::DisconnectVoltageReset;
    settings.recover_voltage = ldc_pkg::RecoverVoltageReset;
    settings.ac_loss_delay = '0;
    settings.undervolt_reload = ldc_pkg::UndervoltReloadReset;
    settings.recover_reload = ldc_pkg::RecoverReloadReset;
    plant.ac_flag = 1'b1;
    plant.ac_loss_timer = ldc_pkg::AcTimerReset;
    plant.undervolt_timer = ldc_pkg::UndervoltReloadReset;
    plant.recover_timer = ldc_pkg::RecoverReloadReset;
    plant.cause_bits = 2'b00;
    plant.latched = 1'b0;
    plant.relay_state = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_power_on_defaults();
    test_corner_cases();
    test_random_operation();
    settle_block(10);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ldc_pkg.sv
hw/rtl/ldc_cfg.sv
hw/rtl/ldc_update.sv
hw/rtl/load_disconnect_controller.sv
dv/load_disconnect_controller_tb.sv
